FILE: rtl/kss_pkg.sv
// Shared types and constants for the k-th smallest selection block.
package kss_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned BIT_W  = 5;
	localparam int unsigned RANK_W = 7;

	localparam logic [WORD_W-1:0] SIGN_BIT = 32'h8000_0000;
	localparam logic [BIT_W-1:0]  TOP_BIT  = 5'd31;
	localparam logic [RANK_W-1:0] RANK_RST = 7'd1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_RANK = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef struct packed {
		logic init;
		logic acc;
		logic decide;
	} kss_ctl_t;

endpackage

FILE: rtl/kth_smallest_select.sv
// Top level: load sequencer, status checks and result register.
//
// Values load one per cycle while busy is low; the beat with last_item closes
// the set. Errors (overflow, rank outside 1..count) are reported in the cycle
// after the closing beat and busy stays low. Otherwise the block runs a radix
// selection over the sign-flipped keys: 32 passes, each reading every loaded
// entry once through the store's single read port, followed by a pipeline
// tail state and a decision state; after the last pass done pulses for one
// cycle. The receiver cannot stall: take the result on done.
module kth_smallest_select import kss_pkg::*; #(
	parameter int MAX_COUNT = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic signed [31:0] value,
	input  logic              last_item,
	output logic              done,
	output logic signed [31:0] selected_value,
	output logic [1:0]        status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [6:0]        cfg_data
);

	localparam int AW = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
	localparam int CW = $clog2(MAX_COUNT + 1);
	localparam int RW = (CW > RANK_W) ? CW : RANK_W;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_TAIL   = 5'b00100,
		S_DECIDE = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     cnt_q;
	logic              ovf_q;
	logic [RANK_W-1:0] rank_q;
	logic [AW-1:0]     addr_q;
	logic              rd_vld_s1;
	logic              done_q;
	logic [WORD_W-1:0] sel_q;
	logic [1:0]        stat_q;

	logic              accept;
	logic              full;
	logic              ovf_now;
	logic [CW-1:0]     cnt_new;
	logic              rank_bad;
	logic              scan_end;
	kss_ctl_t          ctl;
	logic [WORD_W-1:0] rdata;
	logic              last_bit;
	logic [WORD_W-1:0] res_value;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_comb begin
		full     = (cnt_q == CW'(MAX_COUNT));
		ovf_now  = ovf_q || full;
		cnt_new  = full ? cnt_q : cnt_q + 1'b1;
		rank_bad = (rank_q == '0) || (RW'(rank_q) > RW'(cnt_new));
		scan_end = ((CW'(addr_q) + 1'b1) == cnt_q);
		ctl.init   = accept && last_item && !ovf_now && !rank_bad;
		ctl.acc    = rd_vld_s1;
		ctl.decide = (state_q == S_DECIDE);
	end

	kss_store #(
		.DEPTH(MAX_COUNT),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (accept && !full),
		.waddr(cnt_q[AW-1:0]),
		.wdata(value),
		.raddr(addr_q),
		.rdata(rdata)
	);

	kss_radix #(
		.CW(CW)
	) u_radix (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.k_init  (CW'(rank_q)),
		.data    (rdata),
		.last_bit(last_bit),
		.result  (res_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= RANK_RST;
		end else if (cfg_valid && cfg_ready) begin
			rank_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			ovf_q     <= 1'b0;
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
			sel_q     <= '0;
			stat_q    <= ST_OK;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= (state_q == S_SCAN);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= cnt_new;
						ovf_q <= ovf_now;
						if (last_item) begin
							if (ovf_now || rank_bad) begin
								done_q <= 1'b1;
								sel_q  <= '0;
								stat_q <= ovf_now ? ST_OVF : ST_RANK;
								cnt_q  <= '0;
								ovf_q  <= 1'b0;
							end else begin
								addr_q  <= '0;
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					addr_q <= addr_q + 1'b1;
					if (scan_end) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					addr_q  <= '0;
					state_q <= last_bit ? S_FINISH : S_SCAN;
				end
				S_FINISH: begin
					done_q  <= 1'b1;
					sel_q   <= res_value;
					stat_q  <= ST_OK;
					cnt_q   <= '0;
					ovf_q   <= 1'b0;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign selected_value = sel_q;
	assign status         = stat_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (selected_value == '0))
		else $error("error result carries a nonzero value");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_COUNT))
		else $error("load count beyond store depth");

	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_item) |=> (done || busy))
		else $error("closing beat neither reported nor selecting");

	a_idle_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) |-> !rd_vld_s1)
		else $error("read beat still in flight at decision");

endmodule

FILE: rtl/kss_store.sv
// Element store: one write port, one registered read port.
module kss_store import kss_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_s1 <= mem[raddr];
	end

	assign rdata = rd_s1;

endmodule

FILE: rtl/kss_radix.sv
// Shared prefix-compare and count unit for bitwise radix selection.
module kss_radix import kss_pkg::*; #(
	parameter int CW = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kss_ctl_t          ctl,
	input  logic [CW-1:0]     k_init,
	input  logic [WORD_W-1:0] data,
	output logic              last_bit,
	output logic [WORD_W-1:0] result
);

	logic [BIT_W-1:0]  b_q;
	logic [WORD_W-1:0] prefix_q;
	logic [CW-1:0]     k_q;
	logic [CW-1:0]     cnt_q;
	logic [WORD_W-1:0] key;
	logic [WORD_W-1:0] hi_mask;
	logic              match;
	logic              gt;

	always_comb begin
		key     = data ^ SIGN_BIT;
		hi_mask = ({WORD_W{1'b1}} << b_q) << 1;
		match   = (((key ^ prefix_q) & hi_mask) == '0) && !key[b_q];
		gt      = k_q > cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q      <= TOP_BIT;
			prefix_q <= '0;
			k_q      <= '0;
			cnt_q    <= '0;
		end else if (ctl.init) begin
			b_q      <= TOP_BIT;
			prefix_q <= '0;
			k_q      <= k_init;
			cnt_q    <= '0;
		end else if (ctl.decide) begin
			prefix_q[b_q] <= gt;
			if (gt) begin
				k_q <= k_q - cnt_q;
			end
			cnt_q <= '0;
			b_q   <= b_q - 1'b1;
		end else if (ctl.acc && match) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	assign last_bit = (b_q == '0);
	assign result   = prefix_q ^ SIGN_BIT;

endmodule
